// ===== rtl/line_edit_buffer_top_defines.svh =====
// ----------------------------------------------------------------------------
// Line edit buffer assertion macros
// Shared concurrent assertion forms, sampled on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef LINE_EDIT_BUFFER_TOP_DEFINES_SVH
`define LINE_EDIT_BUFFER_TOP_DEFINES_SVH

// same-cycle implication
`define LEB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("leb assertion failed");

// next-cycle implication
`define LEB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("leb assertion failed");

`endif

// ===== rtl/leb_pkg.sv =====
// ----------------------------------------------------------------------------
// Line edit buffer package
// Capacity, field widths, key codes and the word and control types.
// ----------------------------------------------------------------------------
package leb_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = 5;
  localparam int CHAR_W   = 8;
  localparam int KIND_W   = 4;

  localparam logic [KIND_W-1:0] KIND_CHAR      = 4'd0;
  localparam logic [KIND_W-1:0] KIND_HOME      = 4'd1;
  localparam logic [KIND_W-1:0] KIND_END       = 4'd2;
  localparam logic [KIND_W-1:0] KIND_RIGHT     = 4'd3;
  localparam logic [KIND_W-1:0] KIND_LEFT      = 4'd4;
  localparam logic [KIND_W-1:0] KIND_DELETE    = 4'd5;
  localparam logic [KIND_W-1:0] KIND_INSERT    = 4'd6;
  localparam logic [KIND_W-1:0] KIND_BACKSPACE = 4'd7;
  localparam logic [KIND_W-1:0] KIND_ENTER     = 4'd8;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] key_char;
  } in_word_t;

  typedef struct packed {
    logic              char_valid;
    logic [CHAR_W-1:0] char_out;
    logic              last;
    logic [CNT_W-1:0]  line_length;
    logic [CNT_W-1:0]  cursor_pos;
    logic              overwrite_armed;
  } out_word_t;

  typedef struct packed {
    logic accept;
    logic emit;
  } leb_cmd_t;

  typedef struct packed {
    logic out_free;
    logic enter_multi;
    logic rd_last;
  } leb_sts_t;

endpackage

// ===== rtl/leb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Line edit buffer controller
// Takes key words when idle; reads Enter out one char a cycle unless stalled.
// ----------------------------------------------------------------------------
module leb_ctrl import leb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  leb_sts_t sts_i,
  output leb_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state_q, state_d;

  always_comb begin
    in_ready_o   = (state_q == S_IDLE) && sts_i.out_free;
    cmd_o.accept = in_valid_i && in_ready_o;
    cmd_o.emit   = (state_q == S_READ) && sts_i.out_free;
    state_d      = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.accept && sts_i.enter_multi) state_d = S_READ;
      end
      S_READ: begin
        if (cmd_o.emit && sts_i.rd_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/leb_datapath.sv =====
// ----------------------------------------------------------------------------
// Line edit buffer datapath
// Shift-register line store, length, cursor, overwrite flag, output register.
// ----------------------------------------------------------------------------
module leb_datapath import leb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_data_i,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output out_word_t out_data_o,
  input  leb_cmd_t  cmd_i,
  output leb_sts_t  sts_o
);

  logic [CHAR_W-1:0] store_q [CAPACITY];
  logic [CHAR_W-1:0] store_d [CAPACITY];
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  cursor_q, cursor_d;
  logic              flag_q, flag_d;
  logic [CNT_W-1:0]  rd_left_q, rd_left_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_q, out_d;
  logic [CNT_W-1:0]  pos;
  logic              full, is_enter_line;

  localparam logic [CNT_W-1:0] CapCnt = CNT_W'(CAPACITY);

  always_comb begin
    full          = (count_q == CapCnt);
    is_enter_line = (in_data_i.kind == KIND_ENTER) && (count_q != '0);
    pos           = (cursor_q < count_q) ? cursor_q : count_q - CNT_W'(1);

    sts_o.out_free    = !out_valid_q || out_ready_i;
    sts_o.enter_multi = (in_data_i.kind == KIND_ENTER) && (count_q > CNT_W'(1));
    sts_o.rd_last     = (rd_left_q == CNT_W'(1));

    store_d   = store_q;
    count_d   = count_q;
    cursor_d  = cursor_q;
    flag_d    = flag_q;
    rd_left_d = rd_left_q;

    if (cmd_i.accept) begin
      unique case (in_data_i.kind)
        KIND_CHAR: begin
          if (full) begin
            if (flag_q) begin
              for (int i = 0; i < CAPACITY; i++) begin
                if (CNT_W'(i) == pos) store_d[i] = in_data_i.key_char;
              end
              flag_d = 1'b0;
            end
          end else if (flag_q && (cursor_q < count_q)) begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (CNT_W'(i) == cursor_q) store_d[i] = in_data_i.key_char;
            end
            flag_d = 1'b0;
          end else begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (CNT_W'(i) == cursor_q) begin
                store_d[i] = in_data_i.key_char;
              end else if ((i > 0) && (CNT_W'(i) > cursor_q)) begin
                store_d[i] = store_q[(i > 0) ? i - 1 : 0];
              end
            end
            count_d  = count_q + CNT_W'(1);
            cursor_d = cursor_q + CNT_W'(1);
            flag_d   = 1'b0;
          end
        end
        KIND_HOME:  cursor_d = '0;
        KIND_END:   cursor_d = count_q;
        KIND_RIGHT: cursor_d = (cursor_q >= count_q) ? '0 : cursor_q + CNT_W'(1);
        KIND_LEFT:  cursor_d = (cursor_q == '0) ? count_q : cursor_q - CNT_W'(1);
        KIND_DELETE: begin
          if (cursor_q < count_q) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
              if (CNT_W'(i) >= cursor_q) store_d[i] = store_q[i+1];
            end
            count_d = count_q - CNT_W'(1);
          end
        end
        KIND_INSERT: flag_d = 1'b1;
        KIND_BACKSPACE: begin
          if ((cursor_q != '0) && (count_q != '0)) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
              if (CNT_W'(i + 1) >= cursor_q) store_d[i] = store_q[i+1];
            end
            count_d  = count_q - CNT_W'(1);
            cursor_d = cursor_q - CNT_W'(1);
          end
        end
        KIND_ENTER: begin
          if (count_q != '0) begin
            for (int i = 0; i < CAPACITY - 1; i++) store_d[i] = store_q[i+1];
            rd_left_d = count_q - CNT_W'(1);
            count_d   = '0;
            cursor_d  = '0;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.emit) begin
      for (int i = 0; i < CAPACITY - 1; i++) store_d[i] = store_q[i+1];
      rd_left_d = rd_left_q - CNT_W'(1);
    end

    out_d                 = out_q;
    out_d.line_length     = count_d;
    out_d.cursor_pos      = cursor_d;
    out_d.overwrite_armed = flag_d;
    if ((cmd_i.accept && is_enter_line) || cmd_i.emit) begin
      out_d.char_valid = 1'b1;
      out_d.char_out   = store_q[0];
      out_d.last       = cmd_i.emit ? sts_o.rd_last : (count_q == CNT_W'(1));
    end else begin
      out_d.char_valid = 1'b0;
      out_d.char_out   = '0;
      out_d.last       = 1'b1;
    end

    if (cmd_i.accept || cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cursor_q    <= '0;
      flag_q      <= 1'b0;
      rd_left_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      cursor_q    <= cursor_d;
      flag_q      <= flag_d;
      rd_left_q   <= rd_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    store_q <= store_d;
    if (cmd_i.accept || cmd_i.emit) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/line_edit_buffer_top.sv =====
// ----------------------------------------------------------------------------
// Line edit buffer top level
// Single-line key editor; Enter streams the line out one char per word.
//
//   channel | direction | word        | handshake
//   in      | input     | in_word_t   | in_valid_i / in_ready_o
//   out     | output    | out_word_t  | out_valid_o / out_ready_i
//
// An edit key gives one status word from the output register. Enter on a
// line of n chars gives n words, one per cycle unless the output stalls,
// shifted out of the line store; no key is taken until the last one is loaded.
// Reset clears length, cursor and overwrite flag; line store holds no reset.
// A stalled output holds its word and blocks further keys.
// ----------------------------------------------------------------------------
`include "line_edit_buffer_top_defines.svh"

module line_edit_buffer_top import leb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  leb_cmd_t cmd;
  leb_sts_t sts;

  leb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  leb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  `LEB_ASSERT_NOW(a_readout_cleared, out_valid_o && out_data_o.char_valid,
                  (out_data_o.line_length == '0) && (out_data_o.cursor_pos == '0))
  `LEB_ASSERT_NOW(a_status_last, out_valid_o && !out_data_o.char_valid, out_data_o.last)
  `LEB_ASSERT_NEXT(a_readout_blocks, cmd.accept && sts.enter_multi, !in_ready_o)
  `LEB_ASSERT_NOW(a_cursor_in_line, out_valid_o,
                  (out_data_o.cursor_pos <= out_data_o.line_length) &&
                  (out_data_o.line_length <= CNT_W'(CAPACITY)))

endmodule

// ===== tb/line_edit_buffer_top_tb.sv =====
// ----------------------------------------------------------------------------
// Line edit buffer top level testbench
// Feeds key words through the valid/ready input, tracks the expected line,
// cursor and overwrite state in a behavioral copy, and compares every output
// word field by field. Runs directed edits first, then random key sequences
// under changing input and output stall rates.
// ----------------------------------------------------------------------------
module line_edit_buffer_top_tb;
  import leb_pkg::*;

  localparam int QUIET_LIMIT = 5000;

  class line_edit_checker;
    logic [CHAR_W-1:0] line_chars [CAPACITY];
    logic [CNT_W-1:0]  char_total;
    logic [CNT_W-1:0]  cursor;
    logic              overwrite;
    out_word_t         expected_words [$];
    int unsigned       mismatch_count;

    function new();
      char_total     = '0;
      cursor         = '0;
      overwrite      = 1'b0;
      mismatch_count = 0;
      foreach (line_chars[i]) line_chars[i] = '0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void remove_char(int pos);
      for (int i = pos; i + 1 < int'(char_total); i++) line_chars[i] = line_chars[i + 1];
      char_total = char_total - 1'b1;
    endfunction

    function void push_word(logic valid, logic [CHAR_W-1:0] ch, logic fin);
      out_word_t w;
      w.char_valid      = valid;
      w.char_out        = ch;
      w.last            = fin;
      w.line_length     = char_total;
      w.cursor_pos      = cursor;
      w.overwrite_armed = overwrite;
      expected_words.push_back(w);
    endfunction

    function void apply_key(in_word_t key);
      int pos;
      int total;
      case (key.kind)
        KIND_CHAR: begin
          if (char_total >= CAPACITY) begin
            if (overwrite) begin
              pos = (cursor < char_total) ? int'(cursor) : int'(char_total) - 1;
              line_chars[pos] = key.key_char;
              overwrite = 1'b0;
            end
          end else if (overwrite && cursor < char_total) begin
            line_chars[cursor] = key.key_char;
            overwrite = 1'b0;
          end else begin
            for (int i = int'(char_total); i > int'(cursor); i--) line_chars[i] = line_chars[i - 1];
            line_chars[cursor] = key.key_char;
            char_total = char_total + 1'b1;
            cursor     = cursor + 1'b1;
            overwrite  = 1'b0;
          end
        end
        KIND_HOME:  cursor = '0;
        KIND_END:   cursor = char_total;
        KIND_RIGHT: cursor = (cursor >= char_total) ? '0 : cursor + 1'b1;
        KIND_LEFT:  cursor = (cursor == '0) ? char_total : cursor - 1'b1;
        KIND_DELETE: begin
          if (cursor < char_total) remove_char(int'(cursor));
        end
        KIND_INSERT: overwrite = 1'b1;
        KIND_BACKSPACE: begin
          if (cursor > '0 && char_total > '0) begin
            remove_char(int'(cursor) - 1);
            cursor = cursor - 1'b1;
          end
        end
        KIND_ENTER: begin
          if (char_total > '0) begin
            total      = int'(char_total);
            char_total = '0;
            cursor     = '0;
            for (int i = 0; i < total; i++) push_word(1'b1, line_chars[i], i == total - 1);
            return;
          end
        end
        default: ;
      endcase
      push_word(1'b0, '0, 1'b1);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        $error("output word %h with nothing expected", got);
        mismatch_count++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("char_valid", 8'(want.char_valid), 8'(got.char_valid));
      compare_field("char_out", want.char_out, got.char_out);
      compare_field("last", 8'(want.last), 8'(got.last));
      compare_field("line_length", 8'(want.line_length), 8'(got.line_length));
      compare_field("cursor_pos", 8'(want.cursor_pos), 8'(got.cursor_pos));
      compare_field("overwrite_armed", 8'(want.overwrite_armed), 8'(got.overwrite_armed));
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_data_o;

  line_edit_checker line_check;
  int               send_idle_pct;
  int               recv_idle_pct;
  int               quiet_cycles = 0;

  line_edit_buffer_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) line_check.apply_key(in_data_i);
      if (out_valid_o && out_ready_i) line_check.check_word(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("line_edit_buffer_top verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic in_word_t make_key(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] ch);
    in_word_t w;
    w.kind     = kind;
    w.key_char = ch;
    return w;
  endfunction

  function automatic in_word_t random_key(bit fill);
    int                roll;
    logic [KIND_W-1:0] kind;
    roll = $urandom_range(0, 99);
    if (roll < (fill ? 70 : 40)) begin
      kind = KIND_CHAR;
    end else if (roll < 94) begin
      kind = KIND_W'($urandom_range(KIND_HOME, KIND_BACKSPACE));
    end else if (roll < 97) begin
      kind = KIND_ENTER;
    end else begin
      kind = KIND_W'($urandom_range(KIND_ENTER + 1, (1 << KIND_W) - 1));
    end
    return make_key(kind, CHAR_W'($urandom));
  endfunction

  task automatic type_key(in_word_t key);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= key;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // hold input low until every expected word has come out
  task automatic wait_line_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (line_check.pending() != 0);
  endtask

  task automatic run_directed();
    type_key(make_key(KIND_ENTER, 8'h00));
    type_key(make_key(KIND_BACKSPACE, 8'hff));
    type_key(make_key(KIND_DELETE, 8'h00));
    type_key(make_key(KIND_RIGHT, 8'h00));
    type_key(make_key(KIND_LEFT, 8'h00));
    type_key(make_key(KIND_CHAR, 8'h00));
    type_key(make_key(KIND_CHAR, 8'hff));
    type_key(make_key(KIND_CHAR, 8'ha5));
    type_key(make_key(KIND_LEFT, 8'h00));
    type_key(make_key(KIND_HOME, 8'h00));
    type_key(make_key(KIND_LEFT, 8'h00));
    type_key(make_key(KIND_RIGHT, 8'h00));
    type_key(make_key(KIND_RIGHT, 8'h00));
    type_key(make_key(KIND_CHAR, 8'h5a));
    type_key(make_key(KIND_DELETE, 8'h00));
    type_key(make_key(KIND_END, 8'h00));
    type_key(make_key(KIND_DELETE, 8'h00));
    type_key(make_key(KIND_LEFT, 8'h00));
    type_key(make_key(KIND_DELETE, 8'h00));
    type_key(make_key(KIND_BACKSPACE, 8'h00));
    type_key(make_key(KIND_INSERT, 8'h00));
    type_key(make_key(KIND_INSERT, 8'h00));
    type_key(make_key(KIND_HOME, 8'h00));
    type_key(make_key(KIND_CHAR, 8'h3c));
    type_key(make_key(KIND_INSERT, 8'h00));
    type_key(make_key(KIND_END, 8'h00));
    type_key(make_key(KIND_CHAR, 8'h7e));
    type_key(make_key(KIND_W'((1 << KIND_W) - 1), 8'hff));
    type_key(make_key(KIND_W'(KIND_ENTER + 1), 8'h00));
    type_key(make_key(KIND_ENTER, 8'h00));
  endtask

  // key sequences: some lean on chars to fill the line, most end with enter
  task automatic run_random(int count, bit start_full);
    int sent;
    int seq_len;
    bit fill;
    bit first;
    sent  = 0;
    first = start_full;
    while (sent < count) begin
      fill    = first || ($urandom_range(0, 2) == 0);
      seq_len = first ? 40 : $urandom_range(4, 40);
      first   = 1'b0;
      for (int j = 0; j < seq_len && sent < count; j++) begin
        type_key(random_key(fill));
        sent++;
      end
      if ($urandom_range(0, 9) != 0) begin
        type_key(make_key(KIND_ENTER, CHAR_W'($urandom)));
        sent++;
      end
    end
  endtask

  initial begin
    line_check    = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    send_idle_pct = 37;
    recv_idle_pct = 71;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random(110, 1'b1);
    wait_line_idle();

    send_idle_pct = 71;
    recv_idle_pct = 37;
    run_random(130, 1'b0);
    wait_line_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(140, 1'b1);
    wait_line_idle();

    repeat (CAPACITY + 4) @(posedge clk_i);
    if (line_check.mismatch_count == 0 && line_check.pending() == 0) begin
      $display("line_edit_buffer_top verification clean");
    end else begin
      $display("line_edit_buffer_top verification failed");
    end
    $finish;
  end

endmodule
